FILE: rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

    // Screen geometry
    localparam int ROW_COUNT  = 25;
    localparam int COL_COUNT  = 80;
    localparam int CELL_TOTAL = ROW_COUNT * COL_COUNT;
    localparam int LAST_BASE  = (ROW_COUNT - 1) * COL_COUNT;

    localparam int ADDR_W = $clog2(CELL_TOTAL);
    localparam int CUR_W  = $clog2(CELL_TOTAL + 1);
    localparam int COL_W  = $clog2(COL_COUNT);
    localparam int CELL_W = 16;

    // Field widths fixed by the interface
    localparam int REQ_W   = 2;
    localparam int CHAR_W  = 8;
    localparam int ROW_W   = 5;
    localparam int COLIN_W = 7;
    localparam int POS_W   = 11;
    localparam int COLOR_W = 4;
    localparam int TOP_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_STREAM = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POS    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

    // Stream control characters
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'd32;

    localparam int TAB_WIDTH = 4;
    localparam int TAB_CNT_W = $clog2(TAB_WIDTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FG  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP = 2'd2;

    localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;

endpackage

FILE: rtl/text_console_writer_top.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                    | Word
// ----------+-----------+------------------------------+--------------------------------------
// request   | in        | start & !busy                | i_req_type, i_char_code, i_row, i_col
// result    | out       | o_strobe, one cycle          | o_cursor_pos, o_read_data
// config    | in        | i_cfg_valid & o_cfg_ready    | i_cfg_index, i_cfg_data
//
// Steps: printable char, positioned write: accept, work, result; return,
//   newline: accept, result; read: accept, registered RAM read, result; tab: TAB_WIDTH
//   blank writes; clear: all cells. End-of-screen scroll: rows up, last row blanked
//   (rows moved: ROW_COUNT-1-scroll_top, none once scroll_top >= ROW_COUNT-1).
// Reset: synchronous, active low; a clearing pass over every cell follows, busy high.
// Stalls: only busy holds off requests; config is always ready; results cannot stall.

module text_console_writer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tcw_pkg::REQ_W-1:0]      i_req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]     i_char_code,
    input  logic [tcw_pkg::ROW_W-1:0]      i_row,
    input  logic [tcw_pkg::COLIN_W-1:0]    i_col,
    output logic                           o_strobe,
    output logic [tcw_pkg::POS_W-1:0]      o_cursor_pos,
    output logic [tcw_pkg::CELL_W-1:0]     o_read_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import tcw_pkg::*;

    // Sequencer states
    localparam logic [3:0] ST_INIT   = 4'd0;  // post-reset clearing pass
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_PUT    = 4'd2;  // one cell write at the cursor
    localparam logic [3:0] ST_SCR_RD = 4'd3;  // read the cell one row below
    localparam logic [3:0] ST_SCR_WR = 4'd4;  // write it one row up
    localparam logic [3:0] ST_BLANK  = 4'd5;  // blank the last row
    localparam logic [3:0] ST_CLEAR  = 4'd6;
    localparam logic [3:0] ST_POS    = 4'd7;
    localparam logic [3:0] ST_READ   = 4'd8;  // read address presented
    localparam logic [3:0] ST_RWAIT  = 4'd9;  // read data back
    localparam logic [3:0] ST_DONE   = 4'd10; // result strobe

    logic [3:0]           r_state, n_state;
    logic [ADDR_W-1:0]    r_addr, n_addr;
    logic [CUR_W-1:0]     r_cursor, n_cursor;
    logic [COL_W-1:0]     r_ccol, n_ccol;     // cursor % COL_COUNT, kept alongside
    logic [TAB_CNT_W-1:0] r_tab_cnt, n_tab_cnt;
    logic [CHAR_W-1:0]    r_char, n_char;
    logic [CELL_W-1:0]    r_rd, n_rd;

    logic [COLOR_W-1:0]   r_fg, r_bg;
    logic [TOP_W-1:0]     r_scroll_top;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [CELL_W-1:0]    ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [CELL_W-1:0]    ram_rdata;

    logic                 accept;
    logic                 in_range;
    logic [CUR_W:0]       nl_cursor;
    logic [CELL_W-1:0]    blank_word;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = (r_state == ST_DONE);
    assign o_cursor_pos = POS_W'(r_cursor);
    assign o_read_data  = r_rd;

    assign in_range = (32'(i_row) < ROW_COUNT) && (32'(i_col) < COL_COUNT);
    assign blank_word = {{COLOR_W{1'b0}}, r_fg, CH_BLANK};
    // newline target; one bit wider so the saturation compare sees overflow
    assign nl_cursor = {1'b0, r_cursor} + (CUR_W + 1)'(COL_COUNT) - (CUR_W + 1)'(r_ccol);

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg         <= FG_RESET;
            r_bg         <= '0;
            r_scroll_top <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FG:  r_fg         <= i_cfg_data[COLOR_W-1:0];
                CFG_BG:  r_bg         <= i_cfg_data[COLOR_W-1:0];
                CFG_TOP: r_scroll_top <= i_cfg_data[TOP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_cursor  = r_cursor;
        n_ccol    = r_ccol;
        n_tab_cnt = r_tab_cnt;
        n_char    = r_char;
        n_rd      = r_rd;
        case (r_state)
            ST_INIT: begin
                n_addr = r_addr + 1'b1;
                if (32'(r_addr) == CELL_TOTAL - 1) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_rd   = '0;
                    n_char = i_char_code;
                    n_addr = ADDR_W'(32'(i_row) * COL_COUNT + 32'(i_col));
                    case (i_req_type)
                        REQ_STREAM: begin
                            case (i_char_code)
                                CH_NL: begin
                                    n_cursor = (32'(nl_cursor) > CELL_TOTAL) ?
                                               CUR_W'(CELL_TOTAL) : CUR_W'(nl_cursor);
                                    n_ccol   = '0;
                                    n_state  = ST_DONE;
                                end
                                CH_CR: begin
                                    n_cursor = r_cursor - CUR_W'(r_ccol);
                                    n_ccol   = '0;
                                    n_state  = ST_DONE;
                                end
                                CH_TAB: begin
                                    n_char    = CH_BLANK;
                                    n_tab_cnt = TAB_CNT_W'(TAB_WIDTH - 1);
                                    n_state   = ST_PUT;
                                end
                                default: begin
                                    n_tab_cnt = '0;
                                    n_state   = ST_PUT;
                                end
                            endcase
                        end
                        REQ_POS:   n_state = in_range ? ST_POS : ST_DONE;
                        REQ_CLEAR: begin
                            n_addr  = '0;
                            n_state = ST_CLEAR;
                        end
                        default:   n_state = in_range ? ST_READ : ST_DONE;
                    endcase
                end
            end
            ST_PUT: begin
                if (32'(r_cursor) >= CELL_TOTAL) begin
                    // end of screen: scroll, cursor to start of last row
                    n_cursor = CUR_W'(LAST_BASE);
                    n_ccol   = '0;
                    if (32'(r_scroll_top) + 1 < ROW_COUNT) begin
                        n_addr  = ADDR_W'(32'(r_scroll_top) * COL_COUNT);
                        n_state = ST_SCR_RD;
                    end else begin
                        n_addr  = ADDR_W'(LAST_BASE);
                        n_state = ST_BLANK;
                    end
                end else begin
                    n_cursor = r_cursor + 1'b1;
                    n_ccol   = (32'(r_ccol) == COL_COUNT - 1) ? '0 : r_ccol + 1'b1;
                    if (r_tab_cnt != '0) begin
                        n_tab_cnt = r_tab_cnt - 1'b1;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCR_RD: n_state = ST_SCR_WR;
            ST_SCR_WR: begin
                n_addr  = r_addr + 1'b1;
                n_state = (32'(r_addr) == LAST_BASE - 1) ? ST_BLANK : ST_SCR_RD;
            end
            ST_BLANK: begin
                n_addr = r_addr + 1'b1;
                if (32'(r_addr) == CELL_TOTAL - 1) begin
                    n_state = ST_PUT;
                end
            end
            ST_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (32'(r_addr) == CELL_TOTAL - 1) begin
                    n_state = ST_DONE;
                end
            end
            ST_POS:   n_state = ST_DONE;
            ST_READ:  n_state = ST_RWAIT;
            ST_RWAIT: begin
                n_rd    = ram_rdata;
                n_state = ST_DONE;
            end
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_addr    <= '0;
            r_cursor  <= '0;
            r_ccol    <= '0;
            r_tab_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_cursor  <= n_cursor;
            r_ccol    <= n_ccol;
            r_tab_cnt <= n_tab_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_rd   <= n_rd;
    end

    // Screen RAM ports
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = blank_word;
        case (r_state)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_PUT: begin
                ram_we    = (32'(r_cursor) < CELL_TOTAL);
                ram_waddr = r_cursor[ADDR_W-1:0];
                ram_wdata = {r_bg, r_fg, r_char};
            end
            ST_SCR_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            ST_BLANK, ST_CLEAR: ram_we = 1'b1;
            ST_POS: begin
                ram_we    = 1'b1;
                ram_wdata = {{COLOR_W{1'b0}}, r_fg, r_char};
            end
            default: ram_we = 1'b0;
        endcase
    end

    // row below in the scroll read state, else the latched address
    assign ram_raddr = (r_state == ST_SCR_RD) ? r_addr + ADDR_W'(COL_COUNT) : r_addr;

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_TOTAL)
    ) u_screen (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Assertions
    a_cursor_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cursor) <= CELL_TOTAL)
        else $error("cursor beyond screen size");

    a_ccol_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ccol) < COL_COUNT)
        else $error("cursor column out of range");

    a_waddr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (32'(ram_waddr) < CELL_TOTAL))
        else $error("screen write outside the screen");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted word did not raise busy");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !busy && !o_strobe)
        else $error("result strobe not followed by idle");

endmodule

FILE: rtl/tcw_ram.sv
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
